// ===== src/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Types, codes and helpers of the segment completion check.
// ----------------------------------------------------------------------------
package msc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned EXT_W      = 34;

	localparam logic [30:0] UNIT_ONE = 31'd65536;

	typedef enum logic [2:0] {
		MODE_POSITION = 3'd0,
		MODE_TIME     = 3'd1,
		MODE_PRESSURE = 3'd2,
		MODE_FLOW     = 3'd3,
		MODE_MANUAL   = 3'd4
	} end_mode_t;

	typedef enum logic [1:0] {
		DIR_EXTEND  = 2'd0,
		DIR_RETRACT = 2'd1,
		DIR_WINDOW  = 2'd2
	} move_dir_t;

	localparam logic [CFG_IDX_W-1:0] REG_END_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_DIR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TOL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_TOL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_DURATION = 3'd7;

	typedef struct packed {
		logic signed [31:0] axis_position;
		logic signed [31:0] axis_speed;
		logic signed [31:0] axis_pressure;
		logic signed [31:0] axis_flow;
		logic signed [31:0] speed_ref;
		logic signed [31:0] pressure_ref;
		logic signed [31:0] flow_ref;
		logic        [31:0] elapsed_ticks;
		logic        [31:0] sample_time;
		logic               track_dwell;
	} sample_t;

	typedef struct packed {
		logic segment_done;
	} result_t;

	function automatic logic signed [EXT_W-1:0] sext(input logic signed [31:0] v);
		return {{(EXT_W-32){v[31]}}, v};
	endfunction

	function automatic logic [EXT_W-1:0] mag(input logic signed [EXT_W-1:0] v);
		return v[EXT_W-1] ? EXT_W'(-v) : EXT_W'(v);
	endfunction

endpackage

// ===== src/msc_if.sv =====
// ----------------------------------------------------------------------------
// msc_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface msc_sample_if;
	logic              valid;
	logic              ready;
	msc_pkg::sample_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface msc_result_if;
	logic              valid;
	logic              ready;
	msc_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/motion_segment_completion_check_core.sv =====
// ----------------------------------------------------------------------------
// motion_segment_completion_check_core
// End-of-segment detector for a hydraulic axis, one result per sample.
//
// Channel   Direction  Payload
// sample    in         position, speed, pressure, flow, refs, times, track
// result    out        segment_done
// cfg       in         write enable, register index, write data
//
// One item per cycle sustained while results are taken; each item passes
// the input register, the compare logic and the result register in turn.
// Reset clears the dwell state and loads the register defaults.
// A stalled result holds its register; the input stage keeps accepting
// while the result register is free or being taken.
// ----------------------------------------------------------------------------
module motion_segment_completion_check_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msc_pkg::CFG_DATA_W-1:0]    cfg_data,
	msc_sample_if.sink                        sample,
	msc_result_if.source                      result
);
	import msc_pkg::*;

	end_mode_t          mode_q;
	move_dir_t          dir_q;
	logic signed [31:0] target_q;
	logic        [30:0] band_tol_q;
	logic        [30:0] stable_lim_q;
	logic        [30:0] speed_tol_q;
	logic        [31:0] dwell_ticks_q;
	logic        [31:0] run_dur_q;

	logic               dwell_armed_q;
	logic        [31:0] dwell_start_q;

	logic               valid_s1;
	sample_t            item_s1;
	logic               out_valid_q;
	logic               done_q;

	logic               advance;
	logic               raw_c;
	logic               over_c;
	logic               done_c;
	logic               arm_c;
	logic               disarm_c;

	logic signed [EXT_W-1:0] pos_x, spd_x, prs_x, flw_x, sref_x, pref_x, fref_x;
	logic signed [EXT_W-1:0] tgt_x, tol_x, ref_p, ref_f, flow_diff;
	logic        [EXT_W-1:0] settle_x, stable_x;
	logic        [31:0]      dwell_el;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_MANUAL;
			dir_q         <= DIR_WINDOW;
			target_q      <= '0;
			band_tol_q    <= '0;
			stable_lim_q  <= '0;
			speed_tol_q   <= '0;
			dwell_ticks_q <= '0;
			run_dur_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_END_MODE:     mode_q        <= end_mode_t'(cfg_data[2:0]);
				REG_MOVE_DIR:     dir_q         <= move_dir_t'(cfg_data[1:0]);
				REG_TARGET:       target_q      <= $signed(cfg_data);
				REG_BAND_TOL:     band_tol_q    <= cfg_data[30:0];
				REG_STABLE_LIMIT: stable_lim_q  <= cfg_data[30:0];
				REG_SPEED_TOL:    speed_tol_q   <= cfg_data[30:0];
				REG_DWELL_TICKS:  dwell_ticks_q <= cfg_data;
				REG_RUN_DURATION: run_dur_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1 <= sample.data;
		end
	end

	always_comb begin
		pos_x  = sext(item_s1.axis_position);
		spd_x  = sext(item_s1.axis_speed);
		prs_x  = sext(item_s1.axis_pressure);
		flw_x  = sext(item_s1.axis_flow);
		sref_x = sext(item_s1.speed_ref);
		pref_x = sext(item_s1.pressure_ref);
		fref_x = sext(item_s1.flow_ref);
		tgt_x  = sext(target_q);
		tol_x  = $signed({{(EXT_W-31){1'b0}}, band_tol_q});
		stable_x = {{(EXT_W-31){1'b0}}, stable_lim_q};
		if (stable_lim_q != '0) begin
			settle_x = stable_x;
		end else if (speed_tol_q != '0) begin
			settle_x = {{(EXT_W-31){1'b0}}, speed_tol_q};
		end else begin
			settle_x = {{(EXT_W-31){1'b0}}, UNIT_ONE};
		end
		ref_p = (pref_x > 0) ? pref_x : tgt_x;
		ref_f = (fref_x > 0) ? fref_x : tgt_x;
		flow_diff = $signed(mag(flw_x)) - $signed(mag(ref_f));
		raw_c = 1'b0;
		case (mode_q)
			MODE_POSITION: begin
				case (dir_q)
					DIR_EXTEND:  raw_c = pos_x >= (tgt_x - tol_x);
					DIR_RETRACT: raw_c = pos_x <= (tgt_x + tol_x);
					default:     raw_c = mag(pos_x - tgt_x) <= EXT_W'(tol_x);
				endcase
				raw_c = raw_c && (mag(sref_x) <= settle_x) && (mag(spd_x) <= settle_x);
			end
			MODE_TIME:     raw_c = item_s1.elapsed_ticks >= run_dur_q;
			MODE_PRESSURE: raw_c = mag(prs_x - ref_p) <= EXT_W'(tol_x);
			MODE_FLOW:     raw_c = mag(flow_diff) <= EXT_W'(tol_x);
			default:       raw_c = 1'b0;
		endcase
		over_c   = (stable_lim_q != '0) && (mag(spd_x) > stable_x);
		dwell_el = item_s1.sample_time - dwell_start_q;
		done_c   = 1'b0;
		arm_c    = 1'b0;
		disarm_c = 1'b0;
		if (!raw_c || over_c) begin
			disarm_c = item_s1.track_dwell;
		end else if (dwell_ticks_q == '0 || !item_s1.track_dwell) begin
			done_c = 1'b1;
		end else if (!dwell_armed_q) begin
			arm_c = 1'b1;
		end else begin
			done_c = dwell_el >= dwell_ticks_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_armed_q <= 1'b0;
			dwell_start_q <= '0;
		end else if (advance) begin
			if (arm_c) begin
				dwell_armed_q <= 1'b1;
				dwell_start_q <= item_s1.sample_time;
			end else if (disarm_c) begin
				dwell_armed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q <= done_c;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.data.segment_done = done_q;

	a_free_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> sample.ready)
		else $error("input stalled with free result register");

	a_held_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled item dropped");

	a_dwell_done_armed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && done_c && item_s1.track_dwell && dwell_ticks_q != '0 |-> dwell_armed_q)
		else $error("dwell completion without armed window");

	a_arm_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dwell_armed_q) |-> $past(advance))
		else $error("dwell armed without item");

	a_done_mode: assert property (@(posedge clk) disable iff (!arst_n)
		advance && done_c |-> (mode_q == MODE_POSITION || mode_q == MODE_TIME ||
			mode_q == MODE_PRESSURE || mode_q == MODE_FLOW))
		else $error("completion in a non-completing mode");

endmodule
